@@ rtl/scba_pkg.sv @@
package scba_pkg;

  localparam int unsigned NUM_CHUNKS  = 16;
  localparam int unsigned NUM_CLASSES = 8;
  localparam int unsigned CHUNK_W     = 4;
  localparam int unsigned CLASS_W     = 3;
  localparam int unsigned BLOCK_W     = 7;
  localparam int unsigned LINK_W      = 5;
  localparam int unsigned HEAD_W      = 8;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned ACTIVE_W    = 5;
  localparam int unsigned OFFSET_W    = 12;
  localparam int unsigned BADDR_W     = CHUNK_W + BLOCK_W;

  localparam logic [LINK_W-1:0]   NIL_CHUNK  = 5'd16;
  localparam logic [HEAD_W-1:0]   NIL_BLOCK  = 8'hFF;
  localparam logic [BLOCK_W-1:0]  BLOCKS_MAX = 7'd126;
  localparam logic [32:0]         MAXB       = 33'd4048;
  localparam logic [32:0]         MAGIC      = 33'd8;
  // header plus magic
  localparam logic [OFFSET_W-1:0] PAYLOAD_BASE = 12'd56;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_CHUNK  = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [COUNT_W-1:0] avail;
    logic [COUNT_W-1:0] used;
    logic [HEAD_W-1:0]  head;
    logic [LINK_W-1:0]  prev;
    logic [LINK_W-1:0]  next;
  } chunk_rec_t;

  typedef struct packed {
    logic               en;
    logic [CHUNK_W-1:0] addr;
    chunk_rec_t         data;
    logic               we_info;
    logic               we_prev;
    logic               we_next;
  } chunk_wr_t;

  typedef struct packed {
    logic [HEAD_W-1:0]  next;
    logic [BLOCK_W-1:0] span;
  } block_rec_t;

  typedef struct packed {
    logic               en;
    logic [BADDR_W-1:0] addr;
    block_rec_t         data;
  } block_wr_t;

  function automatic logic [COUNT_W-1:0] class_blocks(input logic [CLASS_W-1:0] c);
    case (c)
      3'd0:    return 7'd126;
      3'd1:    return 7'd63;
      3'd2:    return 7'd31;
      3'd3:    return 7'd15;
      3'd4:    return 7'd7;
      3'd5:    return 7'd3;
      default: return 7'd1;
    endcase
  endfunction

  function automatic logic [CLASS_W-1:0] class_of(input logic [32:0] need);
    if (need <= 33'd32)        return 3'd0;
    else if (need <= 33'd64)   return 3'd1;
    else if (need <= 33'd128)  return 3'd2;
    else if (need <= 33'd256)  return 3'd3;
    else if (need <= 33'd512)  return 3'd4;
    else if (need <= 33'd1024) return 3'd5;
    else if (need <= 33'd2048) return 3'd6;
    else                       return 3'd7;
  endfunction

  function automatic logic [OFFSET_W-1:0] offset_of(input logic [CLASS_W-1:0] c,
                                                     input logic [BLOCK_W-1:0] b);
    logic [18:0] sc;
    logic [3:0]  sh;
    sh = {1'b0, c} + 4'd5;
    sc = {12'd0, b} << sh;
    if (c == 3'd7) return PAYLOAD_BASE;
    return PAYLOAD_BASE + sc[OFFSET_W-1:0];
  endfunction

endpackage

@@ rtl/scba_chunk_mem.sv @@
module scba_chunk_mem
  import scba_pkg::*;
(
  input  logic               clk,
  input  chunk_wr_t          wr,
  input  logic [CHUNK_W-1:0] rd_addr,
  output chunk_rec_t         rd_data
);

  chunk_rec_t mem [NUM_CHUNKS];

  // field enables act like byte enables on one write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.we_info) begin
        mem[wr.addr].cls   <= wr.data.cls;
        mem[wr.addr].avail <= wr.data.avail;
        mem[wr.addr].used  <= wr.data.used;
        mem[wr.addr].head  <= wr.data.head;
      end
      if (wr.we_prev) begin
        mem[wr.addr].prev <= wr.data.prev;
      end
      if (wr.we_next) begin
        mem[wr.addr].next <= wr.data.next;
      end
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/scba_block_mem.sv @@
module scba_block_mem
  import scba_pkg::*;
(
  input  logic               clk,
  input  block_wr_t          wr,
  input  logic [BADDR_W-1:0] rd_addr,
  output block_rec_t         rd_data
);

  block_rec_t mem [2**BADDR_W];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/size_class_block_allocator.sv @@
// Size-class block allocator over 16 chunks of 4096 bytes.
// Input channel (in_valid/in_stall): action 0 allocates a block for 'size'
// payload bytes, action 1 frees block 'block_index' of chunk 'chunk_index'.
// Output channel (out_valid/out_stall): one result transaction per input
// transaction carrying status, chunk, block, size class and payload offset.
// One transaction is worked on at a time; a sequencer walks the chunk record
// memory and the block link memory (both synchronous reads with a registered
// output). A new transaction is accepted only once the sequencer is back in
// idle, after the previous one has left its last step, so transactions do
// not overlap.
// A finished result sits in the output register; the next transaction is
// accepted meanwhile and waits in its last step if that register is still
// occupied, so a stalling receiver holds back at most one finished result.
// Reset empties all class lists and frees every chunk; memory contents are
// not cleared and are only read after being written.
module size_class_block_allocator
  import scba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [31:0]         size,
  input  logic [CHUNK_W-1:0]  chunk_index,
  input  logic [BLOCK_W-1:0]  block_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [CHUNK_W-1:0]  out_chunk,
  output logic [BLOCK_W-1:0]  out_block,
  output logic [CLASS_W-1:0]  size_class,
  output logic [OFFSET_W-1:0] payload_offset
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_ARD, S_A1, S_A2, S_F1, S_FIX, S_DETP, S_DETN, S_DONE
  } state_t;

  state_t              state;
  logic                act;
  logic [31:0]         size_q;
  logic [CHUNK_W-1:0]  ch_q;
  logic [BLOCK_W-1:0]  b_q;
  logic [CLASS_W-1:0]  c_q;
  logic                fix_en;
  logic [CHUNK_W-1:0]  fix_tgt;
  logic                det_en;
  logic [LINK_W-1:0]   det_p;
  logic [LINK_W-1:0]   det_n;
  status_t             res_st;
  logic [CHUNK_W-1:0]  res_ch;
  logic [BLOCK_W-1:0]  res_b;
  logic [CLASS_W-1:0]  res_c;
  logic [OFFSET_W-1:0] res_off;

  logic [LINK_W-1:0]   class_head   [NUM_CLASSES];
  logic [ACTIVE_W-1:0] class_active [NUM_CLASSES];
  logic [NUM_CHUNKS-1:0] pool_busy;

  chunk_wr_t  cw;
  chunk_rec_t crec;
  block_wr_t  bw;
  block_rec_t brec;
  logic [BADDR_W-1:0] b_rd_addr;

  // request decode
  logic [32:0]        need;
  logic               too_large;
  logic [CLASS_W-1:0] c_sel;
  logic               claim;
  logic               free_found;
  logic [CHUNK_W-1:0] free_ch;

  // allocate pop
  logic               a1_bad;
  logic               carve;
  logic               a2_bad;
  logic [HEAD_W-1:0]  a2_head;
  logic [COUNT_W-1:0] a2_avail;

  // free push
  logic [CLASS_W-1:0]  f_c;
  logic                f_bad;
  logic                f_att;
  logic [LINK_W-1:0]   f_old;
  logic [COUNT_W-1:0]  f_used;
  logic [ACTIVE_W-1:0] f_act;
  logic                f_empty;
  logic [LINK_W-1:0]   f_lp;
  logic [LINK_W-1:0]   f_ln;
  logic [LINK_W-1:0]   f_head;

  scba_chunk_mem u_chunk_mem (
    .clk     (clk),
    .wr      (cw),
    .rd_addr (ch_q),
    .rd_data (crec)
  );

  scba_block_mem u_block_mem (
    .clk     (clk),
    .wr      (bw),
    .rd_addr (b_rd_addr),
    .rd_data (brec)
  );

  assign in_stall = (state != S_IDLE);

  always_comb begin
    need      = {1'b0, size_q} + MAGIC;
    too_large = need > MAXB;
    c_sel     = class_of(need);
    claim     = class_head[c_sel] == NIL_CHUNK;
    free_found = 1'b0;
    free_ch    = '0;
    for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
      if (!pool_busy[i]) begin
        free_found = 1'b1;
        free_ch    = CHUNK_W'(i);
      end
    end

    a1_bad   = (crec.head >= {1'b0, BLOCKS_MAX}) || (crec.avail == '0);
    carve    = brec.span > 7'd1;
    a2_bad   = carve && ({1'b0, b_q} + 8'd1 >= {1'b0, BLOCKS_MAX});
    a2_head  = carve ? ({1'b0, b_q} + 8'd1) : brec.next;
    a2_avail = crec.avail - 7'd1;

    f_c     = crec.cls;
    f_bad   = (b_q >= class_blocks(f_c)) || (crec.used == '0);
    f_att   = crec.avail == '0;
    f_old   = class_head[f_c];
    f_used  = crec.used - 7'd1;
    f_act   = class_active[f_c] + ACTIVE_W'(f_att);
    f_empty = (f_used == '0) && (f_act != '0);
    f_lp    = f_att ? NIL_CHUNK : crec.prev;
    f_ln    = f_att ? f_old : crec.next;
    f_head  = f_att ? {1'b0, ch_q} : f_old;

    b_rd_addr = (state == S_A1) ? {ch_q, crec.head[BLOCK_W-1:0]} : {ch_q, b_q};

    cw = '0;
    bw = '0;
    case (state)
      S_DEC: begin
        if (!act && !too_large && claim && free_found) begin
          // format a fresh chunk as one untouched span
          cw.en         = 1'b1;
          cw.addr       = free_ch;
          cw.we_info    = 1'b1;
          cw.we_prev    = 1'b1;
          cw.we_next    = 1'b1;
          cw.data.cls   = c_sel;
          cw.data.avail = class_blocks(c_sel);
          cw.data.used  = '0;
          cw.data.head  = '0;
          cw.data.prev  = NIL_CHUNK;
          cw.data.next  = NIL_CHUNK;
          bw.en         = 1'b1;
          bw.addr       = {free_ch, {BLOCK_W{1'b0}}};
          bw.data.next  = NIL_BLOCK;
          bw.data.span  = class_blocks(c_sel);
        end
      end
      S_A2: begin
        if (!a2_bad) begin
          cw.en         = 1'b1;
          cw.addr       = ch_q;
          cw.we_info    = 1'b1;
          cw.data.cls   = crec.cls;
          cw.data.avail = a2_avail;
          cw.data.used  = crec.used + 7'd1;
          cw.data.head  = a2_head;
          if (carve) begin
            bw.en        = 1'b1;
            bw.addr      = {ch_q, b_q + 7'd1};
            bw.data.next = brec.next;
            bw.data.span = brec.span - 7'd1;
          end
        end
      end
      S_F1: begin
        if (!f_bad) begin
          cw.en         = 1'b1;
          cw.addr       = ch_q;
          cw.we_info    = 1'b1;
          cw.we_prev    = f_att;
          cw.we_next    = f_att;
          cw.data.cls   = crec.cls;
          cw.data.avail = crec.avail + 7'd1;
          cw.data.used  = f_used;
          cw.data.head  = {1'b0, b_q};
          cw.data.prev  = NIL_CHUNK;
          cw.data.next  = f_old;
          bw.en         = 1'b1;
          bw.addr       = {ch_q, b_q};
          bw.data.next  = crec.head;
          bw.data.span  = 7'd1;
        end
      end
      S_FIX: begin
        cw.en        = fix_en;
        cw.addr      = fix_tgt;
        cw.we_prev   = 1'b1;
        cw.data.prev = {1'b0, ch_q};
      end
      S_DETP: begin
        cw.en        = det_en && (det_p != NIL_CHUNK);
        cw.addr      = det_p[CHUNK_W-1:0];
        cw.we_next   = 1'b1;
        cw.data.next = det_n;
      end
      S_DETN: begin
        cw.en        = det_en && (det_n != NIL_CHUNK);
        cw.addr      = det_n[CHUNK_W-1:0];
        cw.we_prev   = 1'b1;
        cw.data.prev = det_p;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pool_busy <= '0;
      fix_en    <= 1'b0;
      det_en    <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_head[i]   <= NIL_CHUNK;
        class_active[i] <= '0;
      end
    end else begin
      // the final step reloads the output register itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act    <= action;
            size_q <= size;
            ch_q   <= chunk_index;
            b_q    <= block_index;
            fix_en <= 1'b0;
            det_en <= 1'b0;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          res_st  <= ST_OK;
          res_ch  <= '0;
          res_b   <= '0;
          res_c   <= '0;
          res_off <= '0;
          if (act) begin
            if (!pool_busy[ch_q]) begin
              res_st <= ST_BAD_FREE;
              state  <= S_DONE;
            end else begin
              state <= S_F1;
            end
          end else if (too_large) begin
            res_st <= ST_TOO_LARGE;
            state  <= S_DONE;
          end else begin
            c_q <= c_sel;
            if (!claim) begin
              ch_q  <= class_head[c_sel][CHUNK_W-1:0];
              state <= S_ARD;
            end else if (!free_found) begin
              res_st <= ST_NO_CHUNK;
              state  <= S_DONE;
            end else begin
              ch_q                 <= free_ch;
              pool_busy[free_ch]   <= 1'b1;
              class_head[c_sel]    <= {1'b0, free_ch};
              class_active[c_sel]  <= class_active[c_sel] + 5'd1;
              state                <= S_ARD;
            end
          end
        end
        S_ARD: begin
          state <= S_A1;
        end
        S_A1: begin
          b_q <= crec.head[BLOCK_W-1:0];
          if (a1_bad) begin
            res_st <= ST_NO_CHUNK;
            state  <= S_DONE;
          end else begin
            state <= S_A2;
          end
        end
        S_A2: begin
          if (a2_bad) begin
            res_st <= ST_NO_CHUNK;
            state  <= S_DONE;
          end else begin
            res_ch  <= ch_q;
            res_b   <= b_q;
            res_c   <= c_q;
            res_off <= offset_of(c_q, b_q);
            if (a2_avail == '0) begin
              // chunk now full: unlist it
              det_en <= 1'b1;
              det_p  <= crec.prev;
              det_n  <= crec.next;
              if (class_head[c_q] == {1'b0, ch_q}) begin
                class_head[c_q] <= crec.next;
              end
              if (class_active[c_q] != '0) begin
                class_active[c_q] <= class_active[c_q] - 5'd1;
              end
            end
            state <= S_FIX;
          end
        end
        S_F1: begin
          if (f_bad) begin
            res_st <= ST_BAD_FREE;
            state  <= S_DONE;
          end else begin
            res_ch  <= ch_q;
            res_b   <= b_q;
            res_c   <= f_c;
            res_off <= offset_of(f_c, b_q);
            fix_en  <= f_att && (f_old != NIL_CHUNK);
            fix_tgt <= f_old[CHUNK_W-1:0];
            det_en  <= f_empty;
            det_p   <= f_lp;
            det_n   <= f_ln;
            if (f_empty) begin
              // chunk drained: unlist it and hand it back to the pool
              pool_busy[ch_q]  <= 1'b0;
              class_active[f_c] <= f_act - 5'd1;
              class_head[f_c]   <= (f_head == {1'b0, ch_q}) ? f_ln : f_head;
            end else begin
              class_active[f_c] <= f_act;
              class_head[f_c]   <= f_head;
            end
            state <= S_FIX;
          end
        end
        S_FIX:  state <= S_DETP;
        S_DETP: state <= S_DETN;
        S_DETN: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= res_st;
            out_chunk      <= res_ch;
            out_block      <= res_b;
            size_class     <= res_c;
            payload_offset <= res_off;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |->
      (out_chunk == '0) && (out_block == '0) && (size_class == '0) && (payload_offset == '0))
    else $error("error result carries nonzero fields");

  a_ok_block_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |-> out_block < BLOCKS_MAX)
    else $error("block slot out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_done_drains: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && !out_valid |=> out_valid && (state == S_IDLE))
    else $error("finished result not delivered");

  a_detach_only_listed: assert property (@(posedge clk) disable iff (rst)
    (state == S_F1) && !f_bad && f_empty |=> !pool_busy[$past(ch_q)])
    else $error("drained chunk not returned to pool");

endmodule
